[rtl/qx4a_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_pkg
// Shared types, codes and decode helpers for the x4 quadrature step block.
// ----------------------------------------------------------------------------
package qx4a_pkg;

  localparam int unsigned STEP_W   = 16;
  localparam int unsigned THR_W    = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned DELTA_W  = STEP_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = THR_W;

  localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(250);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Transition code: {new B, new A, old B, old A}
  localparam logic [3:0] CODE_DN_0 = 4'b0100;
  localparam logic [3:0] CODE_DN_1 = 4'b1101;
  localparam logic [3:0] CODE_DN_2 = 4'b1011;
  localparam logic [3:0] CODE_DN_3 = 4'b0010;
  localparam logic [3:0] CODE_UP_0 = 4'b1000;
  localparam logic [3:0] CODE_UP_1 = 4'b1110;
  localparam logic [3:0] CODE_UP_2 = 4'b0111;
  localparam logic [3:0] CODE_UP_3 = 4'b0001;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_STEP,
    REG_FAST_STEP,
    REG_SPEED_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic [STEP_W-1:0] slow_step;
    logic [STEP_W-1:0] fast_step;
    logic [THR_W-1:0]  speed_threshold;
  } cfg_t;

  typedef struct packed {
    logic              pin_a;
    logic              pin_b;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      fast_mode;
  } result_t;

  function automatic dir_t direction_of(input logic [3:0] code);
    dir_t d;
    case (code) inside
      CODE_DN_0, CODE_DN_1, CODE_DN_2, CODE_DN_3: d = DIR_DOWN;
      CODE_UP_0, CODE_UP_1, CODE_UP_2, CODE_UP_3: d = DIR_UP;
      default:                                    d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/qx4a_sample_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_sample_if
// Input channel: one pin sample with its millisecond timestamp per word.
// ----------------------------------------------------------------------------
interface qx4a_sample_if;
  logic        valid;
  logic        ready;
  logic        pin_a;
  logic        pin_b;
  logic [31:0] now_ms;

  modport source (output valid, pin_a, pin_b, now_ms, input ready);
  modport sink   (input valid, pin_a, pin_b, now_ms, output ready);
endinterface
`default_nettype wire

[rtl/qx4a_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_result_if
// Output channel: signed step and speed mode per word.
// ----------------------------------------------------------------------------
interface qx4a_result_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] delta;
  logic               fast_mode;

  modport source (output valid, delta, fast_mode, input ready);
  modport sink   (input valid, delta, fast_mode, output ready);
endinterface
`default_nettype wire

[rtl/qx4a_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_cfg_if
// Configuration write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface qx4a_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/qx4a_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_cfg_regs
// Step size and speed threshold registers with their reset values.
// ----------------------------------------------------------------------------
module qx4a_cfg_regs
  import qx4a_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  qx4a_cfg_if.sink  cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slow_step       <= STEP_W'(1);
      regs.fast_step       <= STEP_W'(10);
      regs.speed_threshold <= THR_W'(250);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SLOW_STEP:       regs.slow_step       <= cfg.data[STEP_W-1:0];
        REG_FAST_STEP:       regs.fast_step       <= cfg.data[STEP_W-1:0];
        REG_SPEED_THRESHOLD: regs.speed_threshold <= cfg.data[THR_W-1:0];
        default: begin
          // index past the register list: drop the word
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/qx4a_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qx4a_core
// Transition decode, saturating window sum and speed mode update.
// ----------------------------------------------------------------------------
module qx4a_core
  import qx4a_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    upd,
  input  wire sample_t smp,
  input  wire cfg_t    regs,
  output result_t      res
);

  logic [1:0]              previous_pins;
  logic signed [SUM_W-1:0] window_sum;
  logic [TIME_W-1:0]       window_start;
  logic                    fast_flag;

  logic [1:0]                pins;
  dir_t                      dir;
  logic [STEP_W-1:0]         size;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W:0]     raw_sum;
  logic signed [SUM_W-1:0]   sat_sum;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W:0]     thr_ext;
  logic                      closed;
  logic                      over;
  logic                      fast_flag_next;

  assign pins = {smp.pin_b, smp.pin_a};
  assign dir  = direction_of({pins, previous_pins});
  assign size = fast_flag ? regs.fast_step : regs.slow_step;

  always_comb begin
    case (dir)
      DIR_UP:   delta = $signed({1'b0, size});
      DIR_DOWN: delta = -$signed({1'b0, size});
      default:  delta = '0;
    endcase
  end

  assign raw_sum = $signed({window_sum[SUM_W-1], window_sum})
                 + $signed({{(SUM_W-DELTA_W+1){delta[DELTA_W-1]}}, delta});

  always_comb begin
    if (raw_sum[SUM_W] != raw_sum[SUM_W-1]) begin
      sat_sum = raw_sum[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = raw_sum[SUM_W-1:0];
    end
  end

  // |sum| > thr without forming the magnitude
  assign sum_ext = $signed({sat_sum[SUM_W-1], sat_sum});
  assign thr_ext = $signed({{(SUM_W+1-THR_W){1'b0}}, regs.speed_threshold});
  assign over    = (sum_ext > thr_ext) || (sum_ext < -thr_ext);
  assign closed  = (smp.now_ms - window_start) > WINDOW_MS;

  assign fast_flag_next = closed ? over : fast_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins <= '0;
      window_sum    <= '0;
      window_start  <= '0;
      fast_flag     <= 1'b0;
    end else if (upd) begin
      previous_pins <= pins;
      fast_flag     <= fast_flag_next;
      if (closed) begin
        window_sum   <= '0;
        window_start <= smp.now_ms;
      end else begin
        window_sum   <= sat_sum;
      end
    end
  end

  assign res.delta     = delta;
  assign res.fast_mode = fast_flag_next;

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (upd && closed) |=> (window_sum == '0 && window_start == $past(smp.now_ms)))
    else $error("window did not restart on close");

  a_mode_holds: assert property (@(posedge clk) disable iff (rst)
    (upd && !closed) |=> (fast_flag == $past(fast_flag)))
    else $error("speed mode changed inside a window");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !upd |=> ($stable(window_sum) && $stable(fast_flag) && $stable(previous_pins)))
    else $error("state moved without an item");

endmodule
`default_nettype wire

[rtl/quadrature_x4_accel_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_x4_accel_step
// x4 quadrature decoder with a speed-dependent step size.
//
//   channel  dir  word contents                       handshake
//   -------  ---  ----------------------------------  ---------------
//   sample   in   pin_a, pin_b, now_ms[31:0]          valid / ready
//   result   out  delta[16:0] signed, fast_mode       valid / ready
//   cfg      in   index[1:0], data[23:0]              valid / ready
//
// One sample word is taken every cycle while sample.ready is high; its result
// word passes the input register, then the result register, and can be taken
// once result.valid is high. The pace is one word per cycle while the result
// is not stalled, set by the state update in the core (decode, saturating add
// and window compare share one register stage).
// rst is synchronous: it clears both pipeline valids, the decode state and
// loads the register defaults (slow 1, fast 10, threshold 250).
// A stalled result holds the result register; the input register then holds
// too, and sample.ready drops only while both are full.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module quadrature_x4_accel_step
  import qx4a_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  qx4a_sample_if.sink     sample,
  qx4a_result_if.source   result,
  qx4a_cfg_if.sink        cfg
);

  cfg_t    regs;
  sample_t s1;
  logic    s1_valid;
  logic    advance;
  logic    upd;
  result_t res_next;
  result_t res;

  qx4a_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Advance the input stage whenever the result register is free or draining.
  assign advance      = !result.valid || result.ready;
  assign upd          = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  // Payload: load on every accepted word, hold otherwise.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1.pin_a  <= sample.pin_a;
      s1.pin_b  <= sample.pin_b;
      s1.now_ms <= sample.now_ms;
    end
  end

  qx4a_core u_core (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .smp  (s1),
    .regs (regs),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res <= res_next;
    end
  end

  assign result.delta     = res.delta;
  assign result.fast_mode = res.fast_mode;

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_valid))
    else $error("result word without a staged sample");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1)))
    else $error("staged sample lost during stall");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> sample.ready)
    else $error("input stalled with empty stage");

endmodule
`default_nettype wire
